[hdl/sid_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sid_pkg
// Shared widths and beat types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS + 2;
    localparam int PROJ_BITS  = 2 * COORD_BITS + 3;
    localparam int DEN_BITS   = 2 * COORD_BITS + 4;
    localparam int NUM_BITS   = 3 * COORD_BITS + 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg0_start_x;
        logic signed [COORD_BITS-1:0] seg0_start_y;
        logic signed [COORD_BITS-1:0] seg0_end_x;
        logic signed [COORD_BITS-1:0] seg0_end_y;
        logic signed [COORD_BITS-1:0] seg1_start_x;
        logic signed [COORD_BITS-1:0] seg1_start_y;
        logic signed [COORD_BITS-1:0] seg1_end_x;
        logic signed [COORD_BITS-1:0] seg1_end_y;
    } in_t;

    typedef struct packed {
        logic                         crossing;
        logic signed [COORD_BITS-1:0] hit_x;
        logic signed [COORD_BITS-1:0] hit_y;
    } out_t;

    // Work handed from one divider cell to the next.
    typedef struct packed {
        logic                         hit;
        logic                         neg_x;
        logic                         neg_y;
        logic [NUM_BITS-1:0]          rem_x;
        logic [NUM_BITS-1:0]          rem_y;
        logic [DEN_BITS-1:0]          den;
        logic [COORD_BITS-1:0]        quo_x;
        logic [COORD_BITS-1:0]        quo_y;
        logic [COORD_BITS-1:0]        a0x;
        logic [COORD_BITS-1:0]        a0y;
    } div_t;

endpackage
`default_nettype wire

[hdl/segment_intersection_2d.sv]
`default_nettype none
// Between input and output beat lie the front stages, one divider cell per quotient bit and an output register.
// Throughput: one beat per cycle while the output does not stall; the chain of one-bit divider cells sets the depth.
// Each stage holds a beat independently, so bubbles close up while the output stalls.
// Reset: rst_n clears all valid flags asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Strict crossing test of two 2D segments with an exactly divided hit point.
// ----------------------------------------------------------------------------
module segment_intersection_2d import sid_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_t      out_data
);

    logic             valid_c [COORD_BITS:0];
    div_t             data_c  [COORD_BITS:0];
    logic             ready_c [COORD_BITS:0];
    logic             front_ready;
    logic             out_valid_reg;
    out_t             out_data_reg;
    logic             out_adv;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign in_stall = !front_ready;

    sid_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_data    (in_data),
        .up_ready   (front_ready),
        .down_valid (valid_c[0]),
        .down_data  (data_c[0]),
        .down_ready (ready_c[0])
    );

    // Most significant quotient bit first.
    for (genvar k = 0; k < COORD_BITS; k++)
    begin : g_cell
        sid_div_cell #(.SHIFT(COORD_BITS - 1 - k)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (valid_c[k]),
            .up_data    (data_c[k]),
            .up_ready   (ready_c[k]),
            .down_valid (valid_c[k+1]),
            .down_data  (data_c[k+1]),
            .down_ready (ready_c[k+1])
        );
    end

    assign ready_c[COORD_BITS] = out_adv;

    div_t                  last;
    logic [COORD_BITS-1:0] ox, oy;

    always_comb
    begin
        last = data_c[COORD_BITS];
        ox = last.neg_x ? -last.quo_x : last.quo_x;
        oy = last.neg_y ? -last.quo_y : last.quo_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= valid_c[COORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            out_data_reg.crossing <= last.hit;
            out_data_reg.hit_x    <= last.hit ? last.a0x + ox : '0;
            out_data_reg.hit_y    <= last.hit ? last.a0y + oy : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // With the output free, every stage moves, so the input never stalls.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output was free");

    // A result without a crossing carries a zero hit point.
    a_zero_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.crossing) |-> (out_data.hit_x == '0 && out_data.hit_y == '0))
        else $error("nonzero hit point without crossing");
`endif

endmodule
`default_nettype wire

[hdl/sid_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sid_front
// Differences, cross products, crossing test and the exact numerators.
// ----------------------------------------------------------------------------
module sid_front import sid_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    input  wire in_t  up_data,
    output logic      up_ready,
    output logic      down_valid,
    output div_t      down_data,
    input  wire logic down_ready
);

    logic [4:0] valid_reg;
    logic [4:0] adv;

    // A stage moves when it is empty or its successor moves.
    always_comb
    begin
        adv[4] = !valid_reg[4] || down_ready;
        adv[3] = !valid_reg[3] || adv[4];
        adv[2] = !valid_reg[2] || adv[3];
        adv[1] = !valid_reg[1] || adv[2];
        adv[0] = !valid_reg[0] || adv[1];
    end

    assign up_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0]) valid_reg[0] <= up_valid;
            if (adv[1]) valid_reg[1] <= valid_reg[0];
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
            if (adv[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    // Stage 1: coordinate differences.
    logic signed [DIFF_BITS-1:0] d0x_reg, d0y_reg, d1x_reg, d1y_reg;
    logic signed [DIFF_BITS-1:0] ex_reg, ey_reg, fx_reg, fy_reg, gx_reg, gy_reg;
    logic [COORD_BITS-1:0]       a0x_reg [3:0];
    logic [COORD_BITS-1:0]       a0y_reg [3:0];

    function automatic logic signed [DIFF_BITS-1:0] sub_c(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        sub_c = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d0x_reg    <= sub_c(up_data.seg0_end_x, up_data.seg0_start_x);
            d0y_reg    <= sub_c(up_data.seg0_end_y, up_data.seg0_start_y);
            d1x_reg    <= sub_c(up_data.seg1_end_x, up_data.seg1_start_x);
            d1y_reg    <= sub_c(up_data.seg1_end_y, up_data.seg1_start_y);
            ex_reg     <= sub_c(up_data.seg0_start_x, up_data.seg1_start_x);
            ey_reg     <= sub_c(up_data.seg0_start_y, up_data.seg1_start_y);
            fx_reg     <= sub_c(up_data.seg0_end_x, up_data.seg1_start_x);
            fy_reg     <= sub_c(up_data.seg0_end_y, up_data.seg1_start_y);
            gx_reg     <= sub_c(up_data.seg1_end_x, up_data.seg0_start_x);
            gy_reg     <= sub_c(up_data.seg1_end_y, up_data.seg0_start_y);
            a0x_reg[0] <= up_data.seg0_start_x;
            a0y_reg[0] <= up_data.seg0_start_y;
        end
    end

    // Stage 2: the eight cross-product terms. The offset a1 - a0 is the
    // negation of a0 - a1, so its terms are negated later.
    logic signed [PROD_BITS-1:0] t0_reg, t1_reg, s0_reg, s1_reg;
    logic signed [PROD_BITS-1:0] p0_reg, p1_reg, q0_reg, q1_reg;
    logic signed [DIFF_BITS-1:0] d0x2_reg, d0y2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            t0_reg     <= ex_reg * d1y_reg;
            t1_reg     <= ey_reg * d1x_reg;
            s0_reg     <= fx_reg * d1y_reg;
            s1_reg     <= fy_reg * d1x_reg;
            p0_reg     <= ex_reg * d0y_reg;
            p1_reg     <= ey_reg * d0x_reg;
            q0_reg     <= gx_reg * d0y_reg;
            q1_reg     <= gy_reg * d0x_reg;
            d0x2_reg   <= d0x_reg;
            d0y2_reg   <= d0y_reg;
            a0x_reg[1] <= a0x_reg[0];
            a0y_reg[1] <= a0y_reg[0];
        end
    end

    // Stage 3: projections and the strict crossing test.
    logic signed [PROJ_BITS-1:0] t_c, s_c, p_c, q_c;
    logic                        hit_c;

    always_comb
    begin
        t_c = t0_reg - t1_reg;
        s_c = s0_reg - s1_reg;
        p_c = p1_reg - p0_reg;
        q_c = q0_reg - q1_reg;
        hit_c = (t_c != '0) && (s_c != '0) && (t_c[PROJ_BITS-1] != s_c[PROJ_BITS-1])
             && (p_c != '0) && (q_c != '0) && (p_c[PROJ_BITS-1] != q_c[PROJ_BITS-1]);
    end

    logic signed [PROJ_BITS-1:0] t_reg;
    logic signed [DEN_BITS-1:0]  den_reg;
    logic                        hit3_reg;
    logic signed [DIFF_BITS-1:0] d0x3_reg, d0y3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            t_reg      <= t_c;
            den_reg    <= t_c - s_c;
            hit3_reg   <= hit_c;
            d0x3_reg   <= d0x2_reg;
            d0y3_reg   <= d0y2_reg;
            a0x_reg[2] <= a0x_reg[1];
            a0y_reg[2] <= a0y_reg[1];
        end
    end

    // Stage 4: exact numerators.
    logic signed [NUM_BITS-1:0] numx_reg, numy_reg;
    logic signed [DEN_BITS-1:0] den4_reg;
    logic                       hit4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            numx_reg   <= d0x3_reg * t_reg;
            numy_reg   <= d0y3_reg * t_reg;
            den4_reg   <= den_reg;
            hit4_reg   <= hit3_reg;
            a0x_reg[3] <= a0x_reg[2];
            a0y_reg[3] <= a0y_reg[2];
        end
    end

    // Stage 5: magnitudes and quotient signs for the divider chain.
    logic dsign;
    assign dsign = den4_reg[DEN_BITS-1];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            down_data.hit   <= hit4_reg;
            down_data.neg_x <= numx_reg[NUM_BITS-1] ^ dsign;
            down_data.neg_y <= numy_reg[NUM_BITS-1] ^ dsign;
            down_data.rem_x <= numx_reg[NUM_BITS-1] ? -numx_reg : numx_reg;
            down_data.rem_y <= numy_reg[NUM_BITS-1] ? -numy_reg : numy_reg;
            down_data.den   <= dsign ? -den4_reg : den4_reg;
            down_data.quo_x <= '0;
            down_data.quo_y <= '0;
            down_data.a0x   <= a0x_reg[3];
            down_data.a0y   <= a0y_reg[3];
        end
    end

    assign down_valid = valid_reg[4];

endmodule
`default_nettype wire

[hdl/sid_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sid_div_cell
// One restoring-division step for both coordinates, settling one quotient bit.
// ----------------------------------------------------------------------------
module sid_div_cell import sid_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    input  wire div_t up_data,
    output logic      up_ready,
    output logic      down_valid,
    output div_t      down_data,
    input  wire logic down_ready
);

    logic                  valid_reg;
    logic [NUM_BITS-1:0]   dsh;
    logic [COORD_BITS-1:0] qbit;
    div_t                  next_c;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        dsh  = NUM_BITS'(up_data.den) << SHIFT;
        qbit = COORD_BITS'(1) << SHIFT;
        next_c = up_data;
        if (up_data.rem_x >= dsh)
        begin
            next_c.rem_x = up_data.rem_x - dsh;
            next_c.quo_x = up_data.quo_x | qbit;
        end
        if (up_data.rem_y >= dsh)
        begin
            next_c.rem_y = up_data.rem_y - dsh;
            next_c.quo_y = up_data.quo_y | qbit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            down_data <= next_c;
        end
    end

    assign down_valid = valid_reg;

endmodule
`default_nettype wire

[tb/segment_intersection_2d_test.sv]
// ----------------------------------------------------------------------------
// segment_intersection_2d_test
// Drives segment pairs into the crossing pipeline and checks every output beat
// against an exact crossing and hit-point calculation done in the testbench.
// ----------------------------------------------------------------------------
module segment_intersection_2d_test import sid_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 5 + COORD_BITS + 1;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;

    out_t expected_hits[$];
    int   mismatches;
    int   idle_cycles;
    bit   timed_out;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_off;

    segment_intersection_2d u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Projection of p onto the perpendicular (dy, -dx), computed exactly.
    function automatic longint perp_dot(longint px, longint py, longint dx, longint dy);
        return px * dy - py * dx;
    endfunction

    function automatic out_t crossing_of(in_t seg);
        longint a0x, a0y, b0x, b0y, a1x, a1y, b1x, b1y;
        longint d0x, d0y, d1x, d1y, t, s, p, q, den, ox, oy;
        out_t r;
        a0x = seg.seg0_start_x; a0y = seg.seg0_start_y;
        b0x = seg.seg0_end_x;   b0y = seg.seg0_end_y;
        a1x = seg.seg1_start_x; a1y = seg.seg1_start_y;
        b1x = seg.seg1_end_x;   b1y = seg.seg1_end_y;
        d0x = b0x - a0x; d0y = b0y - a0y;
        d1x = b1x - a1x; d1y = b1y - a1y;
        t = perp_dot(a0x - a1x, a0y - a1y, d1x, d1y);
        s = perp_dot(b0x - a1x, b0y - a1y, d1x, d1y);
        p = perp_dot(a1x - a0x, a1y - a0y, d0x, d0y);
        q = perp_dot(b1x - a0x, b1y - a0y, d0x, d0y);
        r = '0;
        if (t != 0 && s != 0 && (t < 0) != (s < 0) &&
            p != 0 && q != 0 && (p < 0) != (q < 0))
        begin
            // |d0 * t| stays below 2^52, so 64-bit signed arithmetic is exact;
            // SystemVerilog division truncates toward zero.
            den = t - s;
            ox = (d0x * t) / den;
            oy = (d0y * t) / den;
            r.crossing = 1'b1;
            r.hit_x = COORD_BITS'(a0x + ox);
            r.hit_y = COORD_BITS'(a0y + oy);
        end
        return r;
    endfunction

    // Valid stays high after an accepted beat until the sender idles or pauses.
    task automatic send_segments(in_t seg);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= seg;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected_hits = {expected_hits, crossing_of(seg)};
    endtask

    function automatic in_t random_segments();
        in_t seg;
        int  sh;
        seg = in_t'({$urandom, $urandom, $urandom, $urandom});
        // Mostly short coordinates near a shared center so that crossings are common.
        if ($urandom_range(3) != 0)
        begin
            sh = $urandom_range(15, 4);
            seg.seg0_start_x = $signed(seg.seg0_start_x) >>> sh;
            seg.seg0_start_y = $signed(seg.seg0_start_y) >>> sh;
            seg.seg0_end_x   = $signed(seg.seg0_end_x) >>> sh;
            seg.seg0_end_y   = $signed(seg.seg0_end_y) >>> sh;
            seg.seg1_start_x = $signed(seg.seg1_start_x) >>> sh;
            seg.seg1_start_y = $signed(seg.seg1_start_y) >>> sh;
            seg.seg1_end_x   = $signed(seg.seg1_end_x) >>> sh;
            seg.seg1_end_y   = $signed(seg.seg1_end_y) >>> sh;
        end
        return seg;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        localparam logic signed [15:0] MAXV = 16'sh7fff;
        localparam logic signed [15:0] MINV = -16'sh8000;
        send_segments('{-16'sd100, 16'sd0, 16'sd100, 16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'sd100});
        send_segments('{MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, MINV});
        send_segments('{MAXV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV});
        // Touching at an endpoint.
        send_segments('{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd50, 16'sd0, 16'sd50, 16'sd80});
        // Collinear and overlapping.
        send_segments('{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd50, 16'sd0, 16'sd150, 16'sd0});
        // Parallel.
        send_segments('{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd5, 16'sd100, 16'sd5});
        // Degenerate segment on either side.
        send_segments('{16'sd7, 16'sd7, 16'sd7, 16'sd7, -16'sd50, 16'sd0, 16'sd50, 16'sd9});
        send_segments('{-16'sd50, 16'sd0, 16'sd50, 16'sd9, 16'sd3, 16'sd3, 16'sd3, 16'sd3});
        // Lines cross but the segments do not.
        send_segments('{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd50, -16'sd9, 16'sd50, 16'sd9});
        // Truncation toward zero with negative offsets.
        send_segments('{16'sd10, 16'sd10, -16'sd7, -16'sd3, -16'sd9, 16'sd11, 16'sd5, -16'sd13});
        send_segments('{MAXV, MAXV, MINV, MINV, MAXV, MINV, MINV, MAXV});
        send_segments('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
        send_segments('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        send_segments('{-16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd1});
        wait_drained();
    endtask

    task automatic test_random(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            send_segments(random_segments());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (3 * LATENCY)
        begin
            send_segments(random_segments());
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(330, 13, 76);
        test_random(330, 76, 13);
        // Sender waits here for every outstanding result.
        wait_drained();
        test_backpressure();
        test_random(340, 0, 0);
        wait_drained();
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && !timed_out)
        begin
            $display("segment_intersection_2d_test OK");
        end
        else
        begin
            $display("segment_intersection_2d_test NOT OK");
        end
        $finish;
    end

    // Receiver stall: random, or one long hold-off counted here.
    initial
    begin
        int held;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                for (held = 0; held < 4 * LATENCY; held++)
                begin
                    @(posedge clk);
                end
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Checks each output beat against the oldest prediction.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected beat: %p", out_data);
                end
            end
            else
            begin
                want = expected_hits.pop_front();
                if (out_data.crossing !== want.crossing || out_data.hit_x !== want.hit_x ||
                    out_data.hit_y !== want.hit_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %0b %0d %0d, got %0b %0d %0d",
                                 want.crossing, want.hit_x, want.hit_y,
                                 out_data.crossing, out_data.hit_x, out_data.hit_y);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("segment_intersection_2d_test NOT OK");
            $finish;
        end
    end

endmodule
